// File: design/ksa_pkg.sv
package ksa_pkg;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic               opcode;
      logic [1:0]         stack_id;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pop_value;
      logic [1:0]         status;
      logic               store_full;
      logic               stack_empty;
   } rsp_type;

endpackage

// File: design/k_stacks_shared_array.sv
// NUM_STACKS LIFO stacks share one store of NUM_ENTRIES entries through a
// linked free list. Each request pushes a word onto a stack or pops one
// from it and yields one response with a status (ok, full, empty), the
// popped word, and whether the store is full and the addressed stack is
// empty afterwards. Stack tops, links and data live in synchronous RAMs
// with registered reads. A push reads the stack top and the free head's
// link, then writes back in PUSH_WB; a pop reads the top, reads its link
// and data in POP_RD, then writes back in POP_WB; a refused pop answers
// from POP_RD. One request is in flight at a time; a stalled response
// holds the write-back until the response register frees. The link RAM
// needs no clearing pass after reset: a fill count marks the entries
// never taken from the free list, whose links read as the next index.
module k_stacks_shared_array #(
   parameter int NUM_STACKS  = 4,
   parameter int NUM_ENTRIES = 16,
   parameter int DATA_WIDTH  = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ksa_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ksa_pkg::rsp_type rsp_payload
);

   localparam int PW = $clog2(NUM_ENTRIES + 1);
   localparam int EW = $clog2(NUM_ENTRIES);
   localparam int SW = NUM_STACKS > 1 ? $clog2(NUM_STACKS) : 1;
   localparam int IW = SW > 2 ? SW : 2;
   localparam int XW = DATA_WIDTH > 32 ? DATA_WIDTH : 32;
   localparam logic [PW-1:0] NULL_IDX = PW'(NUM_ENTRIES);

   typedef enum logic [1:0] {IDLE, PUSH_WB, POP_RD, POP_WB} state_type;

   function automatic logic [SW-1:0] sid_to_idx(input logic [1:0] s);
      logic [IW-1:0] w;
      w = IW'(s);
      return w[SW-1:0];
   endfunction

   state_type        state_ff, state_in;
   ksa_pkg::req_type req_ff;
   logic [PW-1:0]    free_head_ff, free_head_in;
   logic [PW-1:0]    fill_ff, fill_in;
   logic [PW-1:0]    entry_ff, entry_in;
   logic [NUM_STACKS-1:0] top_vld_ff, top_vld_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ksa_pkg::rsp_type rsp_ff, rsp_in;

   logic             accept, rsp_free, valid_id;
   logic [SW-1:0]    sid_idx;
   logic [PW-1:0]    top_cur, link_next;

   logic             top_we, top_re, link_we, link_re, data_we, data_re;
   logic [SW-1:0]    top_waddr, top_raddr;
   logic [PW-1:0]    top_wdata, top_rdata;
   logic [EW-1:0]    link_waddr, link_raddr, data_waddr, data_raddr;
   logic [PW-1:0]    link_wdata, link_rdata;
   logic [DATA_WIDTH-1:0] data_wdata, data_rdata;
   logic [XW-1:0]    wide_in, wide_out;

   ksa_ram #(.WIDTH(PW), .DEPTH(NUM_STACKS)) u_top_ram (
      .clock   (clock),
      .wr_en   (top_we),
      .wr_addr (top_waddr),
      .wr_data (top_wdata),
      .rd_en   (top_re),
      .rd_addr (top_raddr),
      .rd_data (top_rdata)
   );

   ksa_ram #(.WIDTH(PW), .DEPTH(NUM_ENTRIES)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_en   (link_re),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   ksa_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NUM_ENTRIES)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (data_waddr),
      .wr_data (data_wdata),
      .rd_en   (data_re),
      .rd_addr (data_raddr),
      .rd_data (data_rdata)
   );

   assign req_ready   = (state_ff == IDLE);
   assign accept      = req_valid && req_ready;
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign sid_idx  = sid_to_idx(req_ff.stack_id);
   assign valid_id = 32'(req_ff.stack_id) < 32'(NUM_STACKS);
   assign top_cur  = (valid_id && top_vld_ff[sid_idx]) ? top_rdata : NULL_IDX;
   // entries at or beyond the fill count were never written; their link is the next index
   assign link_next = (free_head_ff >= fill_ff) ? free_head_ff + PW'(1) : link_rdata;

   assign wide_in  = XW'($unsigned(req_ff.push_value));
   assign wide_out = XW'($signed(data_rdata));

   always_comb begin
      state_in     = state_ff;
      free_head_in = free_head_ff;
      fill_in      = fill_ff;
      entry_in     = entry_ff;
      top_vld_in   = top_vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      top_re     = accept;
      top_raddr  = sid_to_idx(req_payload.stack_id);
      top_we     = 1'b0;
      top_waddr  = sid_idx;
      top_wdata  = link_rdata;
      link_re    = accept;
      link_raddr = free_head_ff[EW-1:0];
      link_we    = 1'b0;
      link_waddr = entry_ff[EW-1:0];
      link_wdata = free_head_ff;
      data_re    = 1'b0;
      data_raddr = top_cur[EW-1:0];
      data_we    = 1'b0;
      data_waddr = free_head_ff[EW-1:0];
      data_wdata = wide_in[DATA_WIDTH-1:0];

      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               state_in = (req_payload.opcode == ksa_pkg::OP_PUSH) ? PUSH_WB : POP_RD;
            end
         end
         PUSH_WB: begin
            if (rsp_free) begin
               state_in             = IDLE;
               rsp_valid_in         = 1'b1;
               rsp_in.pop_value     = '0;
               if (valid_id && free_head_ff != NULL_IDX) begin
                  free_head_in = link_next;
                  if (free_head_ff == fill_ff) begin
                     fill_in = fill_ff + PW'(1);
                  end
                  top_we              = 1'b1;
                  top_wdata           = free_head_ff;
                  top_vld_in[sid_idx] = 1'b1;
                  link_we             = 1'b1;
                  link_waddr          = free_head_ff[EW-1:0];
                  link_wdata          = top_cur;
                  data_we             = 1'b1;
                  rsp_in.status       = ksa_pkg::ST_OK;
                  rsp_in.store_full   = (link_next == NULL_IDX);
                  rsp_in.stack_empty  = 1'b0;
               end else begin
                  rsp_in.status       = ksa_pkg::ST_FULL;
                  rsp_in.store_full   = (free_head_ff == NULL_IDX);
                  rsp_in.stack_empty  = (top_cur == NULL_IDX);
               end
            end
         end
         POP_RD: begin
            entry_in   = top_cur;
            link_raddr = top_cur[EW-1:0];
            if (top_cur != NULL_IDX) begin
               link_re  = 1'b1;
               data_re  = 1'b1;
               state_in = POP_WB;
            end else if (rsp_free) begin
               state_in           = IDLE;
               rsp_valid_in       = 1'b1;
               rsp_in.pop_value   = '0;
               rsp_in.status      = ksa_pkg::ST_EMPTY;
               rsp_in.store_full  = (free_head_ff == NULL_IDX);
               rsp_in.stack_empty = 1'b1;
            end
         end
         POP_WB: begin
            if (rsp_free) begin
               state_in           = IDLE;
               top_we             = 1'b1;
               link_we            = 1'b1;
               free_head_in       = entry_ff;
               rsp_valid_in       = 1'b1;
               rsp_in.pop_value   = wide_out[31:0];
               rsp_in.status      = ksa_pkg::ST_OK;
               rsp_in.store_full  = 1'b0;
               rsp_in.stack_empty = (link_rdata == NULL_IDX);
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         free_head_ff <= '0;
         fill_ff      <= '0;
         top_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         fill_ff      <= fill_in;
         top_vld_ff   <= top_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         req_ff <= req_payload;
      end
      entry_ff <= entry_in;
      rsp_ff   <= rsp_in;
   end

   a_free_head_filled: assert property (@(posedge clock) disable iff (reset)
      free_head_ff != NULL_IDX |-> free_head_ff <= fill_ff)
      else $error("free head beyond fill count");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= NULL_IDX)
      else $error("fill count overflow");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) != IDLE)
      else $error("response loaded outside a finishing state");

   a_push_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == PUSH_WB && rsp_free |=> state_ff == IDLE && rsp_valid_ff)
      else $error("push write-back did not complete");

endmodule

// File: design/ksa_ram.sv
module ksa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int          STACK_COUNT = 4;
   localparam int          SLOT_COUNT  = 16;
   localparam logic [4:0]  NO_SLOT     = 5'd16;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int          HOLD_CYCLES = 300;

   typedef struct {
      ksa_pkg::req_type req;
      bit               typed;
      ksa_pkg::rsp_type want;
   } script_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   ksa_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   ksa_pkg::rsp_type rsp_payload;

   logic [31:0] slot_word [SLOT_COUNT];
   logic [4:0]  slot_next [SLOT_COUNT];
   logic [4:0]  stack_head [STACK_COUNT];
   logic [4:0]  free_slot;

   ksa_pkg::rsp_type expected_rsps [$];
   script_row_type   script [$];
   int          fault_count = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   logic        hold_rsp = 1'b0;
   logic        pressure_armed = 1'b0;
   int unsigned cycle_count = 0;

   k_stacks_shared_array i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Applies one request to the shadow stacks and returns its response.
   function automatic ksa_pkg::rsp_type stack_op(ksa_pkg::req_type r);
      ksa_pkg::rsp_type res;
      logic [4:0]       e;
      res = '0;
      res.status = ksa_pkg::ST_OK;
      if (r.opcode == ksa_pkg::OP_PUSH) begin
         e = free_slot;
         if (e == NO_SLOT) begin
            res.status = ksa_pkg::ST_FULL;
         end else begin
            free_slot = slot_next[e[3:0]];
            slot_next[e[3:0]] = stack_head[r.stack_id];
            stack_head[r.stack_id] = e;
            slot_word[e[3:0]] = r.push_value;
         end
      end else begin
         e = stack_head[r.stack_id];
         if (e == NO_SLOT) begin
            res.status = ksa_pkg::ST_EMPTY;
         end else begin
            stack_head[r.stack_id] = slot_next[e[3:0]];
            slot_next[e[3:0]] = free_slot;
            free_slot = e;
            res.pop_value = slot_word[e[3:0]];
         end
      end
      res.store_full = (free_slot == NO_SLOT);
      res.stack_empty = (stack_head[r.stack_id] == NO_SLOT);
      return res;
   endfunction

   task automatic add_row(logic op, logic [1:0] sid, logic [31:0] value, bit typed,
                          logic [31:0] popped, logic [1:0] st, logic full, logic empty);
      script_row_type row;
      row.req.opcode = op;
      row.req.stack_id = sid;
      row.req.push_value = value;
      row.typed = typed;
      row.want.pop_value = popped;
      row.want.status = st;
      row.want.store_full = full;
      row.want.stack_empty = empty;
      script.push_back(row);
   endtask

   task automatic send_request(ksa_pkg::req_type r, bit typed, ksa_pkg::rsp_type want);
      ksa_pkg::rsp_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      predicted = stack_op(r);
      expected_rsps.push_back(typed ? want : predicted);
   endtask

   // Runs of push-heavy, pop-heavy and mixed requests, mostly on one stack,
   // so the store fills and stacks drain repeatedly.
   task automatic run_phase(int count, int send_idle, int rsp_stall);
      int               push_pct;
      logic [1:0]       focus;
      ksa_pkg::req_type r;
      idle_pct = send_idle;
      stall_pct = rsp_stall;
      for (int n = 0; n < count; n++) begin
         if (n % 32 == 0) begin
            case ($urandom_range(2))
               0: push_pct = 85;
               1: push_pct = 15;
               default: push_pct = 50;
            endcase
            focus = 2'($urandom_range(STACK_COUNT - 1));
         end
         r.opcode = ($urandom_range(99) < push_pct) ? ksa_pkg::OP_PUSH : ksa_pkg::OP_POP;
         r.stack_id = ($urandom_range(9) < 7) ? focus : 2'($urandom_range(STACK_COUNT - 1));
         r.push_value = $urandom;
         send_request(r, 1'b0, '0);
      end
   endtask

   task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h got %h", $time, name, want, got);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin
      ksa_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: response with none expected, got %h", $time, rsp_payload);
               fault_count++;
            end else begin
               want = expected_rsps.pop_front();
               report_field("pop_value", want.pop_value, rsp_payload.pop_value);
               report_field("status", 32'(want.status), 32'(rsp_payload.status));
               report_field("store_full", 32'(want.store_full),
                            32'(rsp_payload.store_full));
               report_field("stack_empty", 32'(want.stack_empty),
                            32'(rsp_payload.stack_empty));
            end
         end
         rsp_ready <= !hold_rsp && ($urandom_range(99) >= stall_pct);
      end
   end

   // long receiver hold-off so the block backs up onto its input
   initial begin
      wait (pressure_armed);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         slot_word[i] = '0;
         slot_next[i] = 5'(i + 1);
      end
      for (int i = 0; i < STACK_COUNT; i++) begin
         stack_head[i] = NO_SLOT;
      end
      free_slot = '0;

      add_row(ksa_pkg::OP_POP, 2'd0, 32'h0, 1'b1, 32'h0, ksa_pkg::ST_EMPTY, 1'b0, 1'b1);
      add_row(ksa_pkg::OP_POP, 2'd3, 32'hffffffff, 1'b1, 32'h0, ksa_pkg::ST_EMPTY,
              1'b0, 1'b1);
      add_row(ksa_pkg::OP_PUSH, 2'd0, 32'h7fffffff, 1'b1, 32'h0, ksa_pkg::ST_OK,
              1'b0, 1'b0);
      add_row(ksa_pkg::OP_PUSH, 2'd1, 32'h80000000, 1'b1, 32'h0, ksa_pkg::ST_OK,
              1'b0, 1'b0);
      add_row(ksa_pkg::OP_POP, 2'd1, 32'h0, 1'b1, 32'h80000000, ksa_pkg::ST_OK,
              1'b0, 1'b1);
      add_row(ksa_pkg::OP_POP, 2'd0, 32'h0, 1'b1, 32'h7fffffff, ksa_pkg::ST_OK,
              1'b0, 1'b1);
      // fill the whole store; the last push leaves no free entry
      for (int i = 0; i < SLOT_COUNT; i++) begin
         add_row(ksa_pkg::OP_PUSH, 2'(i % STACK_COUNT),
                 (i == SLOT_COUNT - 1) ? 32'h12345678 : 32'h11111111 * i,
                 i == SLOT_COUNT - 1, 32'h0, ksa_pkg::ST_OK, 1'b1, 1'b0);
      end
      add_row(ksa_pkg::OP_PUSH, 2'd2, 32'hffffffff, 1'b1, 32'h0, ksa_pkg::ST_FULL,
              1'b1, 1'b0);
      add_row(ksa_pkg::OP_POP, 2'd3, 32'h0, 1'b1, 32'h12345678, ksa_pkg::ST_OK,
              1'b0, 1'b0);
      add_row(ksa_pkg::OP_POP, 2'd2, 32'hdeadbeef, 1'b0, 32'h0, ksa_pkg::ST_OK,
              1'b0, 1'b0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         send_request(script[i].req, script[i].typed, script[i].want);
      end

      run_phase(400, 0, 0);
      run_phase(400, 56, 0);
      pressure_armed <= 1'b1;
      run_phase(50, 0, 0);
      run_phase(400, 0, 56);
      run_phase(400, 36, 36);

      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fault_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
